// ===== rtl/grm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types and constants for the occupancy grid ray marcher: default
// grid geometry, request and response words, register indexes and the
// sequencer states.
// ----------------------------------------------------------------------------
package grm_pkg;

   // Default grid geometry and direction format.
   localparam int GRID_X_DEF    = 128;
   localparam int GRID_Y_DEF    = 128;
   localparam int GRID_Z_DEF    = 16;
   localparam int FRAC_BITS_DEF = 14;

   // Fixed field widths.
   localparam int POS_XY_W   = 7;
   localparam int POS_Z_W    = 4;
   localparam int DIR_W      = 16;
   localparam int RANGE_W    = 10;
   localparam int LIMIT_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LIMIT   = 2'd2;

   // Register reset values.
   localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 10'd64;
   localparam logic [LIMIT_W-1:0] X_LIMIT_RST   = 8'd128;
   localparam logic [LIMIT_W-1:0] Y_LIMIT_RST   = 8'd128;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   typedef struct packed {
      logic                     command;
      logic [POS_XY_W-1:0]      pos_x;
      logic [POS_XY_W-1:0]      pos_y;
      logic [POS_Z_W-1:0]       pos_z;
      logic                     occupied;
      logic signed [DIR_W-1:0]  dir_cos;
      logic signed [DIR_W-1:0]  dir_sin;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               out_of_bounds;
      logic [RANGE_W-1:0] distance;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_STEP,
      ST_CHECK
   } state_type;

endpackage : grm_pkg
`default_nettype wire

// ===== rtl/grm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grm_ram
// Simple dual-port RAM: one write port, one read port with registered read
// data that holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module grm_ram #(
   parameter int WIDTH  = 1,
   parameter int DEPTH  = 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : grm_ram
`default_nettype wire

// ===== rtl/grid_ray_march_range.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_march_range
// A write word is accepted, then its row is read and written back with the new bit.
// A cast marches at most max_range+1 grid steps and ends early on a set cell or when the ray
// leaves the limits. Each step is a row read and a bit test.
// One word is in work at a time; a result not yet taken holds the sequencer.
// Reset: synchronous; afterwards a clearing pass writes GRID_Y*GRID_Z rows
// with req_ready low. Configuration registers take their reset values.
// ----------------------------------------------------------------------------
module grid_ray_march_range #(
   parameter int GRID_X    = grm_pkg::GRID_X_DEF,
   parameter int GRID_Y    = grm_pkg::GRID_Y_DEF,
   parameter int GRID_Z    = grm_pkg::GRID_Z_DEF,
   parameter int FRAC_BITS = grm_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire grm_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output grm_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [grm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [grm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import grm_pkg::*;

   localparam int ROWS  = GRID_Y * GRID_Z;
   localparam int AW    = $clog2(ROWS);
   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   // Accumulator holds origin + half + t*dir; t*dir stays below 2^26.
   localparam int ACC_W = FRAC_BITS + 20;
   localparam int IW    = ACC_W - FRAC_BITS;
   localparam int CW    = 12;

   // Configuration registers.
   logic [RANGE_W-1:0] max_range_ff;
   logic [LIMIT_W-1:0] x_limit_ff;
   logic [LIMIT_W-1:0] y_limit_ff;

   // Control state.
   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Payload state.
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [ACC_W-1:0]    acc_x_ff, acc_x_in;
   logic [ACC_W-1:0]    acc_y_ff, acc_y_in;
   logic [ACC_W-1:0]    dir_x_ff, dir_x_in;
   logic [ACC_W-1:0]    dir_y_ff, dir_y_in;
   logic [POS_Z_W-1:0]  z_ff, z_in;
   logic                layer_ok_ff, layer_ok_in;
   logic [RANGE_W-1:0]  t_ff, t_in;
   logic [AW-1:0]       row_ff, row_in;
   logic [XW-1:0]       xsel_ff, xsel_in;
   logic                bit_ff, bit_in;

   // Grid RAM: one row of GRID_X bits per (z, y).
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [GRID_X-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [GRID_X-1:0] ram_rd_data;

   grm_ram #(
      .WIDTH  (GRID_X),
      .DEPTH  (ROWS),
      .ADDR_W (AW)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Cell position of the current step. The accumulator carries the rounding
   // bias, so a nonpositive value means the coordinate rounds below zero and
   // otherwise the integer part is the rounded cell.
   logic [IW-1:0] x_int, y_int;
   logic          x_pos, y_pos, step_out, out_free, cell_set, in_grid;

   assign x_int    = acc_x_ff[ACC_W-1:FRAC_BITS];
   assign y_int    = acc_y_ff[ACC_W-1:FRAC_BITS];
   assign x_pos    = !acc_x_ff[ACC_W-1] && (acc_x_ff != '0);
   assign y_pos    = !acc_y_ff[ACC_W-1] && (acc_y_ff != '0);
   assign step_out = !x_pos || !y_pos
                     || (x_int >= IW'(x_limit_ff)) || (x_int >= IW'(GRID_X))
                     || (y_int >= IW'(y_limit_ff)) || (y_int >= IW'(GRID_Y));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cell_set = layer_ok_ff && ram_rd_data[xsel_ff];
   assign in_grid  = (CW'(req_data.pos_x) < CW'(GRID_X))
                     && (CW'(req_data.pos_y) < CW'(GRID_Y))
                     && (CW'(req_data.pos_z) < CW'(GRID_Z));

   function automatic logic [AW-1:0] row_of(input logic [POS_Z_W-1:0] z,
                                            input logic [YW-1:0] y);
      return AW'(AW'(z) * AW'(GRID_Y)) + AW'(y);
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RST;
         x_limit_ff   <= X_LIMIT_RST;
         y_limit_ff   <= Y_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_RANGE: max_range_ff <= csr_wdata[RANGE_W-1:0];
            CSR_X_LIMIT:   x_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_Y_LIMIT:   y_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      dir_x_ff    <= dir_x_in;
      dir_y_ff    <= dir_y_in;
      z_ff        <= z_in;
      layer_ok_ff <= layer_ok_in;
      t_ff        <= t_in;
      row_ff      <= row_in;
      xsel_ff     <= xsel_in;
      bit_ff      <= bit_in;
   end

   always_comb begin
      logic [GRID_X-1:0] new_row;

      new_row      = ram_rd_data;
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      dir_x_in     = dir_x_ff;
      dir_y_in     = dir_y_ff;
      z_in         = z_ff;
      layer_ok_in  = layer_ok_ff;
      t_in         = t_ff;
      row_in       = row_ff;
      xsel_in      = xsel_ff;
      bit_in       = bit_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = row_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = row_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_CAST) begin
                  acc_x_in    = (ACC_W'(req_data.pos_x) << FRAC_BITS)
                                + (ACC_W'(1) << (FRAC_BITS - 1));
                  acc_y_in    = (ACC_W'(req_data.pos_y) << FRAC_BITS)
                                + (ACC_W'(1) << (FRAC_BITS - 1));
                  dir_x_in    = {{(ACC_W-DIR_W){req_data.dir_cos[DIR_W-1]}},
                                 req_data.dir_cos};
                  dir_y_in    = {{(ACC_W-DIR_W){req_data.dir_sin[DIR_W-1]}},
                                 req_data.dir_sin};
                  z_in        = req_data.pos_z;
                  layer_ok_in = CW'(req_data.pos_z) < CW'(GRID_Z);
                  t_in        = '0;
                  state_in    = ST_STEP;
               end else if (in_grid) begin
                  row_in   = row_of(req_data.pos_z, YW'(req_data.pos_y));
                  xsel_in  = XW'(req_data.pos_x);
                  bit_in   = req_data.occupied;
                  state_in = ST_WR_READ;
               end
            end
         end
         ST_WR_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WR_WRITE;
         end
         ST_WR_WRITE: begin
            new_row[xsel_ff] = bit_ff;
            ram_wr_en        = 1'b1;
            ram_wr_data      = new_row;
            state_in         = ST_IDLE;
         end
         ST_STEP: begin
            if (step_out) begin
               // Wait here until the result register is free.
               if (out_free) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.hit           = 1'b0;
                  rsp_data_in.out_of_bounds = 1'b1;
                  rsp_data_in.distance      = '0;
                  state_in                  = ST_IDLE;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = row_of(z_ff, YW'(y_int));
               xsel_in     = XW'(x_int);
               acc_x_in    = acc_x_ff + dir_x_ff;
               acc_y_in    = acc_y_ff + dir_y_ff;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cell_set || (t_ff == max_range_ff)) begin
               if (out_free) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.hit           = cell_set;
                  rsp_data_in.out_of_bounds = 1'b0;
                  rsp_data_in.distance      = cell_set ? t_ff : '0;
                  state_in                  = ST_IDLE;
               end
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result never claims both a hit and an exit from the grid.
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.out_of_bounds))
      else $error("hit and out_of_bounds both set");

   // Distance is reported only with a hit.
   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.distance == '0))
      else $error("distance set without hit");

   // The grid is never written while a ray is being marched.
   a_no_wr_cast: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_CHECK) |-> !ram_wr_en)
      else $error("grid written during cast");

   // An accepted cast always starts marching in the next cycle.
   a_cast_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.command == CMD_CAST)
      |=> (state_ff == ST_STEP && t_ff == '0))
      else $error("cast did not start");

endmodule : grid_ray_march_range
`default_nettype wire
